// ----- sv/sefb_pkg.sv -----
`default_nettype none

package sefb_pkg;

	// Framing control bytes.
	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] DLE_BYTE = 8'h10;

	// One payload byte can cause at most eight framed bytes.
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W = $clog2(MAX_RESULTS);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_frame;
		logic       last_of_frame;
		logic [7:0] frame_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
	} result_t;

	// True when a byte must be preceded by an escape byte.
	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = b inside {STX_BYTE, ETX_BYTE, DLE_BYTE};
	endfunction

endpackage

`default_nettype wire

// ----- sv/stx_etx_frame_builder_unit.sv -----
// Channel | Direction | Handshake                   | Beat
// item    | in        | item_valid / item_stall     | item_t: one payload byte and frame flags
// result  | out       | result_valid / result_stall | result_t: one byte of the framed stream
//
// Each item is registered, expanded combinationally into 1 to 8 framed bytes, and
// those bytes leave one per cycle from the result buffer while result_stall is low.
// The first result beat is presented once the item has passed the input register and
// been loaded into the result buffer; it holds the output until all its bytes are taken.
// The next item loads in the cycle its predecessor's final byte is taken.
// arst_n clears all control state and the running check; result_stall holds the
// current beat and backs up into item_stall once the input register is full.
`default_nettype none

module stx_etx_frame_builder_unit
	import sefb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	// Input register.
	item_t             item_s1;
	logic              item_vld_s1;

	// Result buffer and the running check.
	logic [7:0]        buf_q [MAX_RESULTS];
	logic [CNT_W-1:0]  buf_cnt_q;
	logic [IDX_W-1:0]  buf_idx_q;
	logic              buf_etx_q;
	logic [7:0]        chk_q;

	logic              buf_last;
	logic              buf_take;
	logic              buf_done;
	logic              s1_move;
	logic [7:0]        chk_base;
	logic [7:0]        chk_next;
	logic [7:0]        lst [MAX_RESULTS];
	logic [CNT_W-1:0]  lst_cnt;

	// Handshake and buffer control.
	assign result_valid = (buf_cnt_q != '0);
	assign buf_last     = ({1'b0, buf_idx_q} == (buf_cnt_q - CNT_W'(1)));
	assign buf_take     = result_valid & ~result_stall;
	assign buf_done     = buf_take & buf_last;
	assign s1_move      = item_vld_s1 & (~result_valid | buf_done);
	assign item_stall   = item_vld_s1 & ~s1_move;

	assign result.out_byte  = buf_q[buf_idx_q];
	assign result.run_end   = buf_last;
	assign result.frame_end = buf_last & buf_etx_q;

	// Next check: seeded by the length on a frame start, then folded with data.
	assign chk_base = item_s1.first_of_frame ? item_s1.frame_length : chk_q;
	assign chk_next = chk_base ^ item_s1.data_byte;

	// Expand the registered item into its framed, escaped byte sequence.
	always_comb begin
		lst     = '{default: '0};
		lst_cnt = '0;
		if (item_s1.first_of_frame) begin
			lst[lst_cnt[IDX_W-1:0]] = STX_BYTE;
			lst_cnt = lst_cnt + CNT_W'(1);
			if (needs_escape(item_s1.frame_length)) begin
				lst[lst_cnt[IDX_W-1:0]] = DLE_BYTE;
				lst_cnt = lst_cnt + CNT_W'(1);
			end
			lst[lst_cnt[IDX_W-1:0]] = item_s1.frame_length;
			lst_cnt = lst_cnt + CNT_W'(1);
		end
		if (needs_escape(item_s1.data_byte)) begin
			lst[lst_cnt[IDX_W-1:0]] = DLE_BYTE;
			lst_cnt = lst_cnt + CNT_W'(1);
		end
		lst[lst_cnt[IDX_W-1:0]] = item_s1.data_byte;
		lst_cnt = lst_cnt + CNT_W'(1);
		if (item_s1.last_of_frame) begin
			if (needs_escape(chk_next)) begin
				lst[lst_cnt[IDX_W-1:0]] = DLE_BYTE;
				lst_cnt = lst_cnt + CNT_W'(1);
			end
			lst[lst_cnt[IDX_W-1:0]] = chk_next;
			lst_cnt = lst_cnt + CNT_W'(1);
			lst[lst_cnt[IDX_W-1:0]] = ETX_BYTE;
			lst_cnt = lst_cnt + CNT_W'(1);
		end
	end

	// Control state: register occupancy, buffer count and index, running check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			buf_cnt_q   <= '0;
			buf_idx_q   <= '0;
			buf_etx_q   <= 1'b0;
			chk_q       <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				item_vld_s1 <= 1'b1;
			end else if (s1_move) begin
				item_vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				buf_cnt_q <= lst_cnt;
				buf_idx_q <= '0;
				buf_etx_q <= item_s1.last_of_frame;
				chk_q     <= chk_next;
			end else if (buf_done) begin
				buf_cnt_q <= '0;
			end else if (buf_take) begin
				buf_idx_q <= buf_idx_q + IDX_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (s1_move) begin
			buf_q <= lst;
		end
	end

	// The read index always points inside the loaded sequence.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, buf_idx_q} < buf_cnt_q) && (buf_cnt_q <= CNT_W'(MAX_RESULTS)))
		else $error("result buffer index outside loaded sequence");

	// A frame end beat is the closing byte and the last beat of its item.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_end |-> result.run_end && (result.out_byte == ETX_BYTE))
		else $error("frame end beat is not a final closing byte");

	// Loading a new sequence updates the check to the folded value.
	a_chk_update: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> chk_q == $past(chk_next))
		else $error("running check not updated on load");

	// The buffer never holds an empty sequence after a load.
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> result_valid)
		else $error("loaded sequence is empty");

endmodule

`default_nettype wire

// ----- tb/sv/tb_stx_etx_frame_builder_unit.sv -----
`default_nettype none

module tb_stx_etx_frame_builder_unit
	import sefb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Worst case is about 300 payload beats at up to 8 framed beats each, with heavy stalls.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Idle and stall rates in percent, changed per traffic phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Predictor state and bookkeeping.
	logic [7:0] bcc_acc = 8'h00;
	result_t    framed_bytes_due[$];
	int         fail_count = 0;
	int         payload_beats = 0;
	int         frames_closed = 0;
	int         escapes_seen = 0;
	int         framed_beats_checked = 0;
	int         cycle_count = 0;

	stx_etx_frame_builder_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #6 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_stx_etx_frame_builder_unit: FAIL");
			$finish;
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Queue one framed byte, with an escape in front of escapable control values.
	function automatic void push_framed(input logic [7:0] b, input logic escapable,
			input logic closing);
		result_t r;
		if (escapable && (b == STX_BYTE || b == ETX_BYTE || b == DLE_BYTE)) begin
			r.out_byte = DLE_BYTE;
			r.run_end = 1'b0;
			r.frame_end = 1'b0;
			framed_bytes_due = {framed_bytes_due, r};
			escapes_seen++;
		end
		r.out_byte = b;
		r.run_end = 1'b0;
		r.frame_end = closing;
		framed_bytes_due = {framed_bytes_due, r};
	endfunction

	// Expand one accepted payload beat into its framed bytes.
	function automatic void predict_framing(input item_t it);
		if (it.first_of_frame) begin
			push_framed(STX_BYTE, 1'b0, 1'b0);
			push_framed(it.frame_length, 1'b1, 1'b0);
			bcc_acc = it.frame_length;
		end
		push_framed(it.data_byte, 1'b1, 1'b0);
		bcc_acc = bcc_acc ^ it.data_byte;
		if (it.last_of_frame) begin
			push_framed(bcc_acc, 1'b1, 1'b0);
			push_framed(ETX_BYTE, 1'b0, 1'b1);
			frames_closed++;
		end
		// The final framed byte of this beat carries the run marker.
		framed_bytes_due[framed_bytes_due.size() - 1].run_end = 1'b1;
		payload_beats++;
	endfunction

	// Present one payload beat and hold it until it is taken.
	task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
			input logic [7:0] len);
		item_t it;
		bit    took;
		it.data_byte = data;
		it.first_of_frame = first;
		it.last_of_frame = last;
		it.frame_length = len;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			took = !item_stall;
			if (took) predict_framing(it);
			@(posedge clk);
		end while (!took);
	endtask

	// Check each framed beat that the receiver takes at the coming edge.
	always @(negedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (framed_bytes_due.size() == 0) begin
				$error("unexpected framed beat 0x%02h", result.out_byte);
				fail_count++;
			end else begin
				want = framed_bytes_due.pop_front();
				framed_beats_checked++;
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte,
						result.out_byte);
					fail_count++;
				end
				if (result.run_end !== want.run_end) begin
					$error("run_end: expected %0b, got %0b", want.run_end, result.run_end);
					fail_count++;
				end
				if (result.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end,
						result.frame_end);
					fail_count++;
				end
			end
		end
	end

	// Payload value biased toward the control bytes.
	function automatic logic [7:0] pick_payload();
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(2))
				0: return STX_BYTE;
				1: return ETX_BYTE;
				default: return DLE_BYTE;
			endcase
		end
		return 8'($urandom);
	endfunction

	// One-byte frames at the field extremes.
	task automatic test_extremes();
		send_byte(8'h00, 1'b1, 1'b1, 8'h00);
		send_byte(8'hFF, 1'b1, 1'b1, 8'hFF);
		send_byte(8'h80, 1'b1, 1'b1, 8'h01);
		send_byte(8'h7F, 1'b1, 1'b1, 8'hFE);
	endtask

	// Escaping of length, payload and check bytes.
	task automatic test_escaping();
		// Length and every payload byte need an escape here; the check does not.
		send_byte(DLE_BYTE, 1'b1, 1'b0, ETX_BYTE);
		send_byte(STX_BYTE, 1'b0, 1'b0, 8'h00);
		send_byte(ETX_BYTE, 1'b0, 1'b1, 8'h00);
		// Check byte equal to the start byte.
		send_byte(STX_BYTE, 1'b1, 1'b1, 8'h00);
		// Length and payload both escaped, check comes out zero.
		send_byte(DLE_BYTE, 1'b1, 1'b1, DLE_BYTE);
		send_byte(STX_BYTE, 1'b1, 1'b1, STX_BYTE);
	endtask

	// Length mismatch, stray bytes and a frame cut short by a new one.
	task automatic test_special_cases();
		// The declared length is sent as is, even when wrong.
		send_byte(8'hA5, 1'b1, 1'b0, 8'h05);
		send_byte(8'h5A, 1'b0, 1'b1, 8'h99);
		// Bytes outside a frame keep folding into the check.
		send_byte(8'h3C, 1'b0, 1'b0, 8'h00);
		send_byte(8'hC3, 1'b0, 1'b1, 8'h00);
		// A new start before the old frame was closed.
		send_byte(8'h11, 1'b1, 1'b0, 8'h04);
		send_byte(8'h22, 1'b1, 1'b0, 8'h02);
		send_byte(8'h33, 1'b0, 1'b1, 8'h00);
	endtask

	// Mostly well-formed frames with random content, plus loose beats.
	task automatic test_random_traffic(input int n_items, input int send_pct,
			input int recv_pct);
		int sent;
		int len;
		logic [7:0] len_field;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				len_field = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(len);
				for (int i = 0; i < len; i++) begin
					send_byte(pick_payload(), i == 0, i == len - 1,
						(i == 0) ? len_field : 8'($urandom));
					sent++;
				end
			end else begin
				send_byte(pick_payload(), 1'($urandom), 1'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_escaping();
		test_special_cases();
		test_random_traffic(93, 8, 45);
		test_random_traffic(93, 45, 8);
		test_random_traffic(94, 0, 0);

		// Let the output drain, then allow for any beat still in flight.
		item_valid <= 1'b0;
		while (framed_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload beats closing %0d frames; checked %0d framed beats,",
			payload_beats, frames_closed, framed_beats_checked);
		$display("%0d of them escapes, under three idle and stall mixes.", escapes_seen);
		if (fail_count == 0) begin
			$display("tb_stx_etx_frame_builder_unit: PASS");
		end else begin
			$display("tb_stx_etx_frame_builder_unit: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
